[hw/rtl/desrf_pkg.sv]
// Package for the DES round function block: bit-selection tables and S-box contents.
// Depends on nothing; used by desrf_core, the channel interfaces, the top level and the testbench.
package desrf_pkg;

	localparam int HalfWidth = 32;
	localparam int KeyWidth  = 48;
	localparam int NumSbox   = 8;

	typedef logic [HalfWidth-1:0] half_t;
	typedef logic [KeyWidth-1:0]  key_t;
	typedef logic [4:0]           bit_sel_t;
	typedef logic [3:0]           nibble_t;

	// Expansion E, given as the source bit index in the right half for each expanded
	// bit, most significant expanded bit first.
	localparam bit_sel_t E_SRC [KeyWidth] = '{
		5'd0,  5'd31, 5'd30, 5'd29, 5'd28, 5'd27,
		5'd28, 5'd27, 5'd26, 5'd25, 5'd24, 5'd23,
		5'd24, 5'd23, 5'd22, 5'd21, 5'd20, 5'd19,
		5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15,
		5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd11,
		5'd12, 5'd11, 5'd10, 5'd9,  5'd8,  5'd7,
		5'd8,  5'd7,  5'd6,  5'd5,  5'd4,  5'd3,
		5'd4,  5'd3,  5'd2,  5'd1,  5'd0,  5'd31
	};

	// Permutation P, given as the source bit index in the S-box word for each
	// result bit, most significant result bit first.
	localparam bit_sel_t P_SRC [HalfWidth] = '{
		5'd16, 5'd25, 5'd12, 5'd11, 5'd3,  5'd20, 5'd4,  5'd15,
		5'd31, 5'd17, 5'd9,  5'd6,  5'd27, 5'd14, 5'd1,  5'd22,
		5'd30, 5'd24, 5'd8,  5'd18, 5'd0,  5'd5,  5'd29, 5'd23,
		5'd13, 5'd19, 5'd2,  5'd26, 5'd10, 5'd21, 5'd28, 5'd7
	};

	// S-box contents, indexed by row * 16 + column.
	localparam nibble_t SBOX [NumSbox][64] = '{
		'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
		  4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7,
		  4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
		  4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8,
		  4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
		  4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
		  4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
		  4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13},
		'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
		  4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10,
		  4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
		  4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5,
		  4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
		  4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
		  4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
		  4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9},
		'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
		  4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8,
		  4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
		  4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
		  4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
		  4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
		  4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
		  4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12},
		'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
		  4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15,
		  4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
		  4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9,
		  4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
		  4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
		  4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
		  4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14},
		'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
		  4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9,
		  4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
		  4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6,
		  4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
		  4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
		  4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
		  4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3},
		'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
		  4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11,
		  4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
		  4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8,
		  4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
		  4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
		  4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
		  4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13},
		'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
		  4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1,
		  4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
		  4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6,
		  4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
		  4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
		  4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
		  4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12},
		'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
		  4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7,
		  4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
		  4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2,
		  4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
		  4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
		  4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
		  4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}
	};

endpackage

[hw/rtl/desrf_in_if.sv]
// Input channel of the DES round function: right half and round subkey per beat.
// Depends on desrf_pkg for the payload types.
interface desrf_in_if;
	logic                 valid;
	logic                 ready;
	desrf_pkg::half_t     right_half;
	desrf_pkg::key_t      round_subkey;

	modport source (output valid, output right_half, output round_subkey, input ready);
	modport sink (input valid, input right_half, input round_subkey, output ready);
endinterface

[hw/rtl/desrf_out_if.sv]
// Result channel of the DES round function: one f value per beat.
// Depends on desrf_pkg for the payload type.
interface desrf_out_if;
	logic                 valid;
	logic                 ready;
	desrf_pkg::half_t     f_result;

	modport source (output valid, output f_result, input ready);
	modport sink (input valid, input f_result, output ready);
endinterface

[hw/rtl/des_round_function_top.sv]
// DES round function f(R,K) with an input register and a result register.
// Pipeline: two register stages; an accepted beat is captured in the input register, then
// moves to the result register, whose contents are offered on the output channel.
// Throughput: one beat per cycle; a waiting result lets one more beat into the input
// register, and the input stalls only while both registers are full and held.
// Reset: arst_n clears both stage valid flags asynchronously; data registers are not reset.
module des_round_function_top (
	input  logic       clk,
	input  logic       arst_n,
	desrf_in_if.sink   req,
	desrf_out_if.source rsp
);

	logic              valid_s1;
	desrf_pkg::half_t  right_half_s1;
	desrf_pkg::key_t   round_subkey_s1;
	logic              valid_s2;
	desrf_pkg::half_t  f_result_s2;
	desrf_pkg::half_t  core_f;
	logic              adv_s2;
	logic              adv_s1;

	// A stage moves when it is empty or the stage after it is moving.
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			right_half_s1   <= req.right_half;
			round_subkey_s1 <= req.round_subkey;
		end
		if (adv_s2 && valid_s1) begin
			f_result_s2 <= core_f;
		end
	end

	desrf_core u_core (
		.right_half   (right_half_s1),
		.round_subkey (round_subkey_s1),
		.f_result     (core_f)
	);

	assign rsp.valid    = valid_s2;
	assign rsp.f_result = f_result_s2;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted beat did not reach the input register");

	a_s1_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> rsp.valid && rsp.f_result == $past(core_f))
		else $error("result register did not capture the f value");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp.valid && !rsp.ready |-> !req.ready)
		else $error("input accepted while both stages were held");
`endif

endmodule

[hw/rtl/desrf_core.sv]
// Combinational DES f function: expansion, key mix, eight S-boxes and P.
// Depends on desrf_pkg for the tables.
module desrf_core (
	input  desrf_pkg::half_t right_half,
	input  desrf_pkg::key_t  round_subkey,
	output desrf_pkg::half_t f_result
);

	desrf_pkg::key_t  expanded;
	desrf_pkg::key_t  mixed;
	desrf_pkg::half_t sbox_word;

	for (genvar i = 0; i < desrf_pkg::KeyWidth; i++) begin : g_expand
		assign expanded[desrf_pkg::KeyWidth-1-i] = right_half[desrf_pkg::E_SRC[i]];
	end

	assign mixed = expanded ^ round_subkey;

	// The outer bits of each group pick the row, the inner four the column.
	for (genvar i = 0; i < desrf_pkg::NumSbox; i++) begin : g_sbox
		logic [5:0] grp;
		assign grp = mixed[desrf_pkg::KeyWidth-1-6*i -: 6];
		assign sbox_word[desrf_pkg::HalfWidth-1-4*i -: 4] =
			desrf_pkg::SBOX[i][{grp[5], grp[0], grp[4:1]}];
	end

	for (genvar i = 0; i < desrf_pkg::HalfWidth; i++) begin : g_perm
		assign f_result[desrf_pkg::HalfWidth-1-i] = sbox_word[desrf_pkg::P_SRC[i]];
	end

endmodule

[tb/sv/tb_des_round_function_top.sv]
`timescale 1ns / 1ps
// Testbench for des_round_function_top: a self-contained DES f(R,K) predictor checks every result.
// Depends on desrf_pkg, desrf_in_if, desrf_out_if and the RTL of the block under test.
module tb_des_round_function_top;

	typedef struct packed {
		desrf_pkg::half_t r;
		desrf_pkg::key_t  k;
	} f_args_t;

	// DES tables in the published numbering: positions count from 1 at the MSB.
	localparam int E_POS [48] = '{
		32, 1, 2, 3, 4, 5,
		4, 5, 6, 7, 8, 9,
		8, 9, 10, 11, 12, 13,
		12, 13, 14, 15, 16, 17,
		16, 17, 18, 19, 20, 21,
		20, 21, 22, 23, 24, 25,
		24, 25, 26, 27, 28, 29,
		28, 29, 30, 31, 32, 1
	};

	localparam int P_POS [32] = '{
		16, 7, 20, 21, 29, 12, 28, 17,
		1, 15, 23, 26, 5, 18, 31, 10,
		2, 8, 24, 14, 32, 27, 3, 9,
		19, 13, 30, 6, 22, 11, 4, 25
	};

	localparam int DES_SBOX [8][64] = '{
		'{14, 4, 13, 1, 2, 15, 11, 8, 3, 10, 6, 12, 5, 9, 0, 7,
		  0, 15, 7, 4, 14, 2, 13, 1, 10, 6, 12, 11, 9, 5, 3, 8,
		  4, 1, 14, 8, 13, 6, 2, 11, 15, 12, 9, 7, 3, 10, 5, 0,
		  15, 12, 8, 2, 4, 9, 1, 7, 5, 11, 3, 14, 10, 0, 6, 13},
		'{15, 1, 8, 14, 6, 11, 3, 4, 9, 7, 2, 13, 12, 0, 5, 10,
		  3, 13, 4, 7, 15, 2, 8, 14, 12, 0, 1, 10, 6, 9, 11, 5,
		  0, 14, 7, 11, 10, 4, 13, 1, 5, 8, 12, 6, 9, 3, 2, 15,
		  13, 8, 10, 1, 3, 15, 4, 2, 11, 6, 7, 12, 0, 5, 14, 9},
		'{10, 0, 9, 14, 6, 3, 15, 5, 1, 13, 12, 7, 11, 4, 2, 8,
		  13, 7, 0, 9, 3, 4, 6, 10, 2, 8, 5, 14, 12, 11, 15, 1,
		  13, 6, 4, 9, 8, 15, 3, 0, 11, 1, 2, 12, 5, 10, 14, 7,
		  1, 10, 13, 0, 6, 9, 8, 7, 4, 15, 14, 3, 11, 5, 2, 12},
		'{7, 13, 14, 3, 0, 6, 9, 10, 1, 2, 8, 5, 11, 12, 4, 15,
		  13, 8, 11, 5, 6, 15, 0, 3, 4, 7, 2, 12, 1, 10, 14, 9,
		  10, 6, 9, 0, 12, 11, 7, 13, 15, 1, 3, 14, 5, 2, 8, 4,
		  3, 15, 0, 6, 10, 1, 13, 8, 9, 4, 5, 11, 12, 7, 2, 14},
		'{2, 12, 4, 1, 7, 10, 11, 6, 8, 5, 3, 15, 13, 0, 14, 9,
		  14, 11, 2, 12, 4, 7, 13, 1, 5, 0, 15, 10, 3, 9, 8, 6,
		  4, 2, 1, 11, 10, 13, 7, 8, 15, 9, 12, 5, 6, 3, 0, 14,
		  11, 8, 12, 7, 1, 14, 2, 13, 6, 15, 0, 9, 10, 4, 5, 3},
		'{12, 1, 10, 15, 9, 2, 6, 8, 0, 13, 3, 4, 14, 7, 5, 11,
		  10, 15, 4, 2, 7, 12, 9, 5, 6, 1, 13, 14, 0, 11, 3, 8,
		  9, 14, 15, 5, 2, 8, 12, 3, 7, 0, 4, 10, 1, 13, 11, 6,
		  4, 3, 2, 12, 9, 5, 15, 10, 11, 14, 1, 7, 6, 0, 8, 13},
		'{4, 11, 2, 14, 15, 0, 8, 13, 3, 12, 9, 7, 5, 10, 6, 1,
		  13, 0, 11, 7, 4, 9, 1, 10, 14, 3, 5, 12, 2, 15, 8, 6,
		  1, 4, 11, 13, 12, 3, 7, 14, 10, 15, 6, 8, 0, 5, 9, 2,
		  6, 11, 13, 8, 1, 4, 10, 7, 9, 5, 0, 15, 14, 2, 3, 12},
		'{13, 2, 8, 4, 6, 15, 11, 1, 10, 9, 3, 14, 5, 0, 12, 7,
		  1, 15, 13, 8, 10, 3, 7, 4, 12, 5, 6, 11, 0, 14, 9, 2,
		  7, 11, 4, 1, 9, 12, 14, 2, 0, 6, 10, 13, 15, 3, 5, 8,
		  2, 1, 14, 7, 4, 10, 8, 13, 15, 12, 9, 0, 3, 5, 6, 11}
	};

	localparam int NUM_RANDOM = 600;

	logic clk;
	logic arst_n;

	desrf_in_if  req ();
	desrf_out_if rsp ();

	des_round_function_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	f_args_t          pending_blocks [$];
	desrf_pkg::half_t f_expected [$];
	f_args_t          next_blk;
	desrf_pkg::half_t want_f;
	logic    in_taken;
	bit      in_calm;
	bit      out_calm;
	int      in_gap;
	int      out_stall;
	int      beats_in;
	int      results_seen;
	int      idle_in_cycles;
	int      stall_cycles;
	int      mismatches;

	// Expansion, key mix, S-box lookup and P permutation, all in DES bit order.
	function automatic desrf_pkg::half_t des_feistel_f(desrf_pkg::half_t r,
		desrf_pkg::key_t k);
		logic [47:0]      x;
		logic [5:0]       g;
		desrf_pkg::half_t s;
		desrf_pkg::half_t f;
		for (int i = 0; i < 48; i++)
			x[47 - i] = r[32 - E_POS[i]];
		x ^= k;
		for (int i = 0; i < 8; i++) begin
			g = x[47 - 6 * i -: 6];
			// Outer bits pick the row, inner four the column: row * 16 + column.
			s[31 - 4 * i -: 4] = 4'(DES_SBOX[i][{g[5], g[0], g[4:1]}]);
		end
		for (int i = 0; i < 32; i++)
			f[31 - i] = s[32 - P_POS[i]];
		return f;
	endfunction

	// Mostly short gaps, now and then a long one; none while the side is calm.
	function automatic int idle_len(bit calm);
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_block(desrf_pkg::half_t r, desrf_pkg::key_t k);
		f_args_t blk;
		blk.r = r;
		blk.k = k;
		pending_blocks.push_back(blk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Input side: a new beat goes out at the falling edge once the last one was taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (req.valid && !in_taken) begin
				// Beat still waiting for ready: hold it.
			end else if (in_gap > 0) begin
				req.valid <= 1'b0;
				in_gap--;
				idle_in_cycles++;
			end else if (pending_blocks.size() > 0) begin
				next_blk = pending_blocks.pop_front();
				req.valid        <= 1'b1;
				req.right_half   <= next_blk.r;
				req.round_subkey <= next_blk.k;
				if ($urandom_range(0, 29) == 0)
					in_calm = !in_calm;
				in_gap = idle_len(in_calm);
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Result side: ready drops for random stretches.
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 59) == 0)
				out_calm = !out_calm;
			if (out_stall > 0) begin
				rsp.ready <= 1'b0;
				out_stall--;
				stall_cycles++;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					out_stall = idle_len(out_calm);
			end
		end
	end

	// Both channels are sampled at the rising edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= req.valid && req.ready;
			if (rsp.valid && rsp.ready) begin
				if (f_expected.size() == 0) begin
					$error("f_result: expected nothing, got %h", rsp.f_result);
					mismatches++;
				end else begin
					want_f = f_expected.pop_front();
					results_seen++;
					if (rsp.f_result !== want_f) begin
						$error("f_result: expected %h, got %h", want_f, rsp.f_result);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				f_expected.push_back(des_feistel_f(req.right_half, req.round_subkey));
				beats_in++;
			end
		end
	end

	initial begin
		desrf_pkg::half_t r;
		desrf_pkg::key_t  k;
		f_args_t shared;
		int      mode;
		logic [5:0] grp;

		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.right_half   = '0;
		req.round_subkey = '0;
		rsp.ready        = 1'b0;
		in_taken         = 1'b0;
		in_calm          = 1'b0;
		out_calm         = 1'b0;
		in_gap           = 0;
		out_stall        = 0;
		beats_in         = 0;
		results_seen     = 0;
		idle_in_cycles   = 0;
		stall_cycles     = 0;
		mismatches       = 0;

		// Directed: field extremes, alternating patterns and a known first-round value.
		add_block('0, '0);
		add_block('1, '1);
		add_block('0, '1);
		add_block('1, '0);
		add_block(32'hAAAA_AAAA, 48'h5555_5555_5555);
		add_block(32'h5555_5555, 48'hAAAA_AAAA_AAAA);
		add_block(32'hF0AA_F0AA, 48'h1B02_EFFC_7072);
		add_block(32'h8000_0001, 48'h0000_0000_0000);
		add_block(32'h0000_0000, 48'h8000_0000_0001);
		// With R = 0 each S-box sees the key group directly: corners of row and column.
		add_block('0, {8{6'd0}});
		add_block('0, {8{6'd63}});
		add_block('0, {8{6'd1}});
		add_block('0, {8{6'd62}});
		add_block('0, {8{6'd32}});
		add_block('0, {8{6'd31}});
		add_block('0, {8{6'd33}});
		add_block('0, {8{6'd30}});

		shared.k = {16'($urandom()), 32'($urandom())};
		for (int n = 0; n < NUM_RANDOM; n++) begin
			mode = $urandom_range(0, 9);
			r = $urandom();
			k = {16'($urandom()), 32'($urandom())};
			case (mode)
				6: begin
					// Zero half: every S-box input comes straight from the key.
					r = '0;
					for (int i = 0; i < 8; i++) begin
						grp = 6'($urandom_range(0, 63));
						k[47 - 6 * i -: 6] = grp;
					end
				end
				7: begin
					// Single set or cleared bits.
					r = desrf_pkg::half_t'(1) << $urandom_range(0, 31);
					k = desrf_pkg::key_t'(1) << $urandom_range(0, 47);
					if ($urandom_range(0, 1) == 1) begin
						r = ~r;
						k = ~k;
					end
				end
				8: begin
					// Several halves under one round key, as in a cipher run.
					k = shared.k;
					if ($urandom_range(0, 15) == 0)
						shared.k = {16'($urandom()), 32'($urandom())};
				end
				9: begin
					r = ($urandom_range(0, 1) == 1) ? '1 : '0;
				end
				default: begin
				end
			endcase
			add_block(r, k);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_blocks.size() > 0 || req.valid || f_expected.size() > 0)
			@(negedge clk);
		repeat (6) @(posedge clk);

		$display("Sent %0d beats with %0d idle input cycles; checked %0d results",
			beats_in, idle_in_cycles, results_seen);
		$display("across %0d output stall cycles, %0d mismatches.", stall_cycles, mismatches);
		if (mismatches == 0)
			$display("tb_des_round_function_top: clean");
		else
			$display("tb_des_round_function_top: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d results still outstanding.", f_expected.size());
		$display("tb_des_round_function_top: errors");
		$finish;
	end

endmodule
